FILE: sv/dsvf_pkg.sv
package dsvf_pkg;

    // Q.20 fixed point throughout.
    localparam int FRAC = 20;
    localparam int SW   = 24;              // sample and output width
    localparam int DW   = 32;              // saturated wide values and states
    localparam int LW   = DW + 1;          // sum of two saturated values
    localparam int AW   = 38;              // multiplier operand A
    localparam int BW   = 24;              // multiplier operand B
    localparam int QW   = AW + BW - FRAC;  // scaled product
    localparam int ACCW = 44;              // adder width
    localparam int NUMW = 28;              // damping numerator
    localparam int DENW = 26;              // damping denominator
    localparam int DVSW = DENW - 1;        // positive divisor magnitude
    localparam int DVDW = NUMW + FRAC;     // dividend magnitude
    localparam int AXW  = 5;               // APB address width

    localparam logic signed [BW-1:0] ONE_B    = 24'sd1048576;
    localparam logic signed [BW-1:0] TWO_B    = 24'sd2097152;
    localparam logic signed [BW-1:0] FB_TENTH = 24'sd104858;

    localparam logic [2:0] REG_AB_MIX        = 3'd0;
    localparam logic [2:0] REG_COMB_MIX      = 3'd1;
    localparam logic [2:0] REG_FM_SOURCE_MIX = 3'd2;
    localparam logic [2:0] REG_MORPH_ONE     = 3'd3;
    localparam logic [2:0] REG_MORPH_TWO     = 3'd4;
    localparam logic [2:0] REG_OUT_GAIN_ONE  = 3'd5;
    localparam logic [2:0] REG_OUT_GAIN_TWO  = 3'd6;
    localparam logic [2:0] REG_OMEGA_LIMIT   = 3'd7;

    typedef struct packed {
        logic        [20:0] ab_mix;
        logic signed [21:0] comb_mix;
        logic        [20:0] fm_source_mix;
        logic signed [21:0] morph_stage_one;
        logic signed [21:0] morph_stage_two;
        logic signed [21:0] out_gain_one;
        logic signed [21:0] out_gain_two;
        logic        [21:0] omega_limit;
    } cfg_t;

    // Sequencer steps. The order matters: plain steps advance to the next member.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
        ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5,
        ST_DIV,
        ST_G6, ST_G7, ST_G8, ST_G9, ST_G10, ST_G11, ST_G12, ST_G13, ST_G14,
        ST_G15, ST_G16,
        ST_P0, ST_P1, ST_P2,
        ST_F0, ST_F1, ST_F2
    } step_t;

    typedef struct packed {
        step_t step;
        logic  stage;
        logic  load_in;
        logic  div_start;
        logic  out_load;
    } cmd_t;

    // (a * b) / 2^20, rounded toward minus infinity.
    function automatic logic signed [QW-1:0] mulq(input logic signed [AW-1:0] a,
                                                  input logic signed [BW-1:0] b);
        logic signed [AW+BW-1:0] p;
        p = a * b;
        return p[AW+BW-1:FRAC];
    endfunction

    function automatic logic signed [DW-1:0] sat_to32(input logic signed [ACCW-1:0] v);
        logic signed [DW-1:0] r;
        if (v[ACCW-1:DW-1] == '0 || v[ACCW-1:DW-1] == '1) begin
            r = v[DW-1:0];
        end else if (v[ACCW-1]) begin
            r = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sat_to24(input logic signed [ACCW-1:0] v);
        logic signed [SW-1:0] r;
        if (v[ACCW-1:SW-1] == '0 || v[ACCW-1:SW-1] == '1) begin
            r = v[SW-1:0];
        end else if (v[ACCW-1]) begin
            r = {1'b1, {(SW-1){1'b0}}};
        end else begin
            r = {1'b0, {(SW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: sv/dsvf_div.sv
module dsvf_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [dsvf_pkg::NUMW-1:0]   num,
    input  logic signed [dsvf_pkg::DENW-1:0]   den,
    output logic                               done,
    output logic signed [dsvf_pkg::BW-1:0]     quot
);

    localparam int CNTW = $clog2(dsvf_pkg::DVDW + 1);
    localparam logic [dsvf_pkg::DVDW-1:0] Q_POS_MAX = dsvf_pkg::DVDW'(8388607);
    localparam logic [dsvf_pkg::DVDW-1:0] Q_NEG_MAX = dsvf_pkg::DVDW'(8388608);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNTW-1:0]             cnt_reg;
    logic [dsvf_pkg::DVDW-1:0]   dvd_reg;
    logic [dsvf_pkg::DVSW-1:0]   rem_reg;
    logic [dsvf_pkg::DVSW-1:0]   dvs_reg;
    logic                        neg_reg;

    logic [dsvf_pkg::NUMW-1:0]   num_mag;
    logic [dsvf_pkg::DVSW:0]     rem_sh;
    logic                        fits;

    always_comb begin
        num_mag = num[dsvf_pkg::NUMW-1] ? dsvf_pkg::NUMW'(-num) : dsvf_pkg::NUMW'(num);
        rem_sh  = {rem_reg, dvd_reg[dsvf_pkg::DVDW-1]};
        fits    = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(dsvf_pkg::DVDW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle; quotient bits shift into dvd_reg.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num_mag, {dsvf_pkg::FRAC{1'b0}}};
            rem_reg <= '0;
            neg_reg <= num[dsvf_pkg::NUMW-1];
            if (den <= 0) begin
                dvs_reg <= dsvf_pkg::DVSW'(1);
            end else begin
                dvs_reg <= den[dsvf_pkg::DVSW-1:0];
            end
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[dsvf_pkg::DVDW-2:0], fits};
            if (fits) begin
                rem_reg <= dsvf_pkg::DVSW'(rem_sh - {1'b0, dvs_reg});
            end else begin
                rem_reg <= rem_sh[dsvf_pkg::DVSW-1:0];
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            if (dvd_reg > Q_NEG_MAX) begin
                quot = {1'b1, {(dsvf_pkg::BW-1){1'b0}}};
            end else begin
                quot = -$signed(dvd_reg[dsvf_pkg::BW-1:0]);
            end
        end else begin
            if (dvd_reg > Q_POS_MAX) begin
                quot = {1'b0, {(dsvf_pkg::BW-1){1'b1}}};
            end else begin
                quot = $signed(dvd_reg[dsvf_pkg::BW-1:0]);
            end
        end
    end

    assign done = done_reg;

endmodule

FILE: sv/dsvf_datapath.sv
module dsvf_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dsvf_pkg::cmd_t         cmd,
    input  dsvf_pkg::cfg_t         cfg,
    input  logic signed [23:0]     sample_a,
    input  logic signed [23:0]     sample_b,
    input  logic signed [23:0]     sample_comb,
    input  logic        [20:0]     resonance,
    input  logic        [21:0]     cut_one,
    input  logic signed [23:0]     fm_one,
    input  logic        [21:0]     cut_two,
    input  logic signed [23:0]     fm_two,
    input  logic signed [21:0]     serial_gain,
    input  logic signed [21:0]     parallel_gain,
    output logic                   div_done,
    output logic signed [23:0]     out_sample
);

    localparam int AW   = dsvf_pkg::AW;
    localparam int BW   = dsvf_pkg::BW;
    localparam int QW   = dsvf_pkg::QW;
    localparam int DW   = dsvf_pkg::DW;
    localparam int LW   = dsvf_pkg::LW;
    localparam int ACCW = dsvf_pkg::ACCW;
    localparam int SW   = dsvf_pkg::SW;

    // Captured word.
    logic signed [SW-1:0] a_reg, b_reg, comb_reg;
    logic        [20:0]   res_reg;
    logic        [21:0]   cut_one_reg, cut_two_reg;
    logic signed [SW-1:0] fm_one_reg, fm_two_reg;
    logic signed [21:0]   ser_reg, par_reg;

    // Working registers.
    logic signed [QW-1:0]             mq_reg, t0_reg;
    logic signed [DW-1:0]             mix_reg, fmv_reg, in_reg, x_reg, fo_reg;
    logic signed [DW-1:0]             i1_reg, i2_reg, y1_reg, y2_reg;
    logic signed [dsvf_pkg::NUMW-1:0] num_reg;
    logic signed [dsvf_pkg::DENW-1:0] den_reg;
    logic signed [BW-1:0]             w_reg, att_reg;
    logic signed [AW-1:0]             t_reg, hp_reg;
    logic signed [LW-1:0]             lp_reg, bp_reg;
    logic signed [ACCW-1:0]           acc_reg;
    logic signed [SW-1:0]             out_reg;

    // Filter state, one entry per stage.
    logic signed [DW-1:0] fir_reg  [2];
    logic signed [DW-1:0] band_reg [2];
    logic signed [DW-1:0] low_reg  [2];
    logic signed [SW-1:0] satfb_reg[2];

    logic                 st;
    logic        [21:0]   cut_s, w0;
    logic signed [BW-1:0] fm_s, w0_s, cut_sg, res_s, ab_s, fsm_s;
    logic signed [BW-1:0] c24, cabs, m24, mabs;
    logic signed [BW-1:0] morph_neg, morph_pos, morph_mid, one_m_comb;
    logic signed [LW-1:0] s_cl;
    logic signed [BW-1:0] s_b, s_abs, sat_b;
    logic signed [DW-1:0] fir_s, band_s, low_s, lim_sg, w32, w_lim;
    logic signed [ACCW-1:0] sum_t0, x_sum, den_sum, w_sum, fo_sum, t_sum, hp_sum, acc_sum;
    logic signed [DW-1:0] i2_val;
    logic signed [LW-1:0] lp_sum;
    logic signed [BW-1:0] div_q;

    logic                 mul_en;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;

    dsvf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        st      = cmd.stage;
        cut_s   = st ? cut_two_reg : cut_one_reg;
        fm_s    = st ? fm_two_reg : fm_one_reg;
        m24     = st ? BW'(cfg.morph_stage_two) : BW'(cfg.morph_stage_one);
        w0      = (cut_s < cfg.omega_limit) ? cut_s : cfg.omega_limit;
        w0_s    = $signed({2'b00, w0});
        cut_sg  = $signed({2'b00, cut_s});
        res_s   = $signed({3'b000, res_reg});
        ab_s    = $signed({3'b000, cfg.ab_mix});
        fsm_s   = $signed({3'b000, cfg.fm_source_mix});
        fir_s   = fir_reg[st];
        band_s  = band_reg[st];
        low_s   = low_reg[st];

        c24        = BW'(cfg.comb_mix);
        cabs       = c24[BW-1] ? -c24 : c24;
        one_m_comb = dsvf_pkg::ONE_B - cabs;

        mabs      = m24[BW-1] ? -m24 : m24;
        morph_neg = m24[BW-1] ? -m24 : '0;
        morph_pos = (m24 > 0) ? m24 : '0;
        morph_mid = dsvf_pkg::ONE_B - mabs;

        // Saturator input is the bandpass output limited to plus or minus two.
        if (bp_reg > LW'(dsvf_pkg::TWO_B)) begin
            s_cl = LW'(dsvf_pkg::TWO_B);
        end else if (bp_reg < -LW'(dsvf_pkg::TWO_B)) begin
            s_cl = -LW'(dsvf_pkg::TWO_B);
        end else begin
            s_cl = bp_reg;
        end
        s_b   = s_cl[BW-1:0];
        s_abs = s_b[BW-1] ? -s_b : s_b;
        sat_b = dsvf_pkg::ONE_B - (s_abs >>> 2);

        sum_t0  = ACCW'(t0_reg) + ACCW'(mq_reg);
        x_sum   = ACCW'(in_reg) + ACCW'(mq_reg);
        den_sum = ACCW'(mq_reg) + ACCW'(dsvf_pkg::TWO_B) - ACCW'(w0_s);
        w_sum   = ACCW'(cut_sg) + ACCW'(mq_reg);
        w32     = dsvf_pkg::sat_to32(w_sum);
        lim_sg  = $signed({10'b0, cfg.omega_limit});
        w_lim   = (w32 > lim_sg) ? lim_sg : w32;
        fo_sum  = ACCW'(fir_s) + ACCW'(x_reg);
        t_sum   = ACCW'(fo_reg) - (ACCW'(mq_reg) + ACCW'(low_s));
        i2_val  = dsvf_pkg::sat_to32(ACCW'(mq_reg) + ACCW'(low_s));
        lp_sum  = LW'(i2_val) + LW'(low_s);
        hp_sum  = ACCW'(x_reg) - (ACCW'(mq_reg) + ACCW'(lp_reg));
        acc_sum = acc_reg + ACCW'(mq_reg);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.step)
            dsvf_pkg::ST_M0: begin
                mul_a = AW'(b_reg);
                mul_b = dsvf_pkg::ONE_B - ab_s;
            end
            dsvf_pkg::ST_M1: begin
                mul_a = AW'(a_reg);
                mul_b = ab_s;
            end
            dsvf_pkg::ST_M2: begin
                mul_a = AW'(a_reg);
                mul_b = fsm_s;
            end
            dsvf_pkg::ST_M3: begin
                mul_a = AW'(b_reg);
                mul_b = dsvf_pkg::ONE_B - fsm_s;
            end
            dsvf_pkg::ST_M4: begin
                mul_a = AW'(mix_reg);
                mul_b = one_m_comb;
            end
            dsvf_pkg::ST_M5: begin
                mul_a = AW'(comb_reg);
                mul_b = c24;
            end
            dsvf_pkg::ST_G0: begin
                mul_a = AW'(satfb_reg[st]);
                mul_b = dsvf_pkg::FB_TENTH;
            end
            dsvf_pkg::ST_G1: begin
                mul_a = AW'(dsvf_pkg::TWO_B + w0_s);
                mul_b = dsvf_pkg::TWO_B - w0_s;
            end
            dsvf_pkg::ST_G2: begin
                mul_a = mq_reg[AW-1:0];
                mul_b = res_s;
            end
            dsvf_pkg::ST_G3: begin
                mul_a = AW'(res_s);
                mul_b = w0_s;
            end
            dsvf_pkg::ST_G4: begin
                mul_a = AW'(fmv_reg);
                mul_b = fm_s;
            end
            dsvf_pkg::ST_G6: begin
                mul_a = AW'(band_s);
                mul_b = div_q;
            end
            dsvf_pkg::ST_G8: begin
                mul_a = t_reg;
                mul_b = w_reg;
            end
            dsvf_pkg::ST_G10: begin
                mul_a = AW'(i1_reg);
                mul_b = w_reg;
            end
            dsvf_pkg::ST_G11: begin
                mul_a = AW'(i1_reg);
                mul_b = att_reg;
            end
            dsvf_pkg::ST_G12: begin
                mul_a = AW'(lp_reg);
                mul_b = morph_neg;
            end
            dsvf_pkg::ST_G13: begin
                mul_a = AW'(bp_reg);
                mul_b = morph_mid;
            end
            dsvf_pkg::ST_G14: begin
                mul_a = hp_reg;
                mul_b = morph_pos;
            end
            dsvf_pkg::ST_G15: begin
                mul_a = AW'(s_b);
                mul_b = sat_b;
            end
            dsvf_pkg::ST_P0: begin
                mul_a = AW'(y1_reg);
                mul_b = BW'(ser_reg);
            end
            dsvf_pkg::ST_P1: begin
                mul_a = AW'(mix_reg);
                mul_b = BW'(par_reg);
            end
            dsvf_pkg::ST_F0: begin
                mul_a = AW'(y1_reg);
                mul_b = BW'(cfg.out_gain_one);
            end
            dsvf_pkg::ST_F1: begin
                mul_a = AW'(y2_reg);
                mul_b = BW'(cfg.out_gain_two);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            mq_reg <= dsvf_pkg::mulq(mul_a, mul_b);
        end
        if (cmd.load_in) begin
            a_reg       <= sample_a;
            b_reg       <= sample_b;
            comb_reg    <= sample_comb;
            res_reg     <= resonance;
            cut_one_reg <= cut_one;
            fm_one_reg  <= fm_one;
            cut_two_reg <= cut_two;
            fm_two_reg  <= fm_two;
            ser_reg     <= serial_gain;
            par_reg     <= parallel_gain;
        end
        // A step that uses a product takes the one from the step before it.
        unique case (cmd.step) inside
            dsvf_pkg::ST_M1, dsvf_pkg::ST_M3, dsvf_pkg::ST_M5,
            dsvf_pkg::ST_P1, dsvf_pkg::ST_F1: begin
                t0_reg <= mq_reg;
            end
            dsvf_pkg::ST_M2: begin
                mix_reg <= dsvf_pkg::sat_to32(sum_t0);
            end
            dsvf_pkg::ST_M4: begin
                fmv_reg <= dsvf_pkg::sat_to32(sum_t0);
            end
            dsvf_pkg::ST_M6: begin
                mix_reg <= dsvf_pkg::sat_to32(sum_t0);
                in_reg  <= dsvf_pkg::sat_to32(sum_t0);
            end
            dsvf_pkg::ST_G1: begin
                x_reg <= dsvf_pkg::sat_to32(x_sum);
            end
            dsvf_pkg::ST_G3: begin
                num_reg <= mq_reg[dsvf_pkg::NUMW-1:0];
            end
            dsvf_pkg::ST_G4: begin
                den_reg <= {den_sum[dsvf_pkg::DENW-2:0], 1'b0};
            end
            dsvf_pkg::ST_G5: begin
                w_reg <= dsvf_pkg::sat_to24(ACCW'(w_lim));
            end
            dsvf_pkg::ST_G6: begin
                att_reg <= div_q;
                fo_reg  <= fo_sum[DW+1:2];
            end
            dsvf_pkg::ST_G7: begin
                t_reg <= t_sum[AW-1:0];
            end
            dsvf_pkg::ST_G9: begin
                i1_reg <= dsvf_pkg::sat_to32(ACCW'(mq_reg) + ACCW'(band_s));
            end
            dsvf_pkg::ST_G11: begin
                i2_reg <= i2_val;
                lp_reg <= lp_sum;
                bp_reg <= LW'(i1_reg) + LW'(i1_reg);
            end
            dsvf_pkg::ST_G12: begin
                hp_reg <= hp_sum[AW-1:0];
            end
            dsvf_pkg::ST_G13: begin
                acc_reg <= ACCW'(mq_reg);
            end
            dsvf_pkg::ST_G14: begin
                acc_reg <= acc_sum;
            end
            dsvf_pkg::ST_G15: begin
                if (st) begin
                    y2_reg <= dsvf_pkg::sat_to32(acc_sum);
                end else begin
                    y1_reg <= dsvf_pkg::sat_to32(acc_sum);
                end
            end
            dsvf_pkg::ST_P2: begin
                in_reg <= dsvf_pkg::sat_to32(sum_t0);
            end
            dsvf_pkg::ST_F2: begin
                if (cmd.out_load) begin
                    out_reg <= dsvf_pkg::sat_to24(sum_t0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                fir_reg[i]   <= '0;
                band_reg[i]  <= '0;
                low_reg[i]   <= '0;
                satfb_reg[i] <= '0;
            end
        end else begin
            unique case (cmd.step) inside
                dsvf_pkg::ST_G6: begin
                    fir_reg[st] <= x_reg;
                end
                dsvf_pkg::ST_G12: begin
                    band_reg[st] <= i1_reg;
                    low_reg[st]  <= i2_reg;
                end
                dsvf_pkg::ST_G16: begin
                    satfb_reg[st] <= mq_reg[SW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_sample = out_reg;

endmodule

FILE: sv/dsvf_ctrl.sv
module dsvf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  logic             div_done,
    output dsvf_pkg::cmd_t   cmd
);

    dsvf_pkg::step_t state_reg, state_next;
    logic            stage_reg, stage_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dsvf_pkg::ST_IDLE;
            stage_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stage_reg   <= stage_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        out_free      = !m_valid_reg || m_ready;
        state_next    = state_reg;
        stage_next    = stage_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd.step      = state_reg;
        cmd.stage     = stage_reg;
        cmd.load_in   = 1'b0;
        cmd.div_start = (state_reg == dsvf_pkg::ST_G5);
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            dsvf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    stage_next  = 1'b0;
                    state_next  = dsvf_pkg::ST_M0;
                end
            end
            dsvf_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = dsvf_pkg::ST_G6;
                end
            end
            dsvf_pkg::ST_G16: begin
                state_next = stage_reg ? dsvf_pkg::ST_F0 : dsvf_pkg::ST_P0;
            end
            dsvf_pkg::ST_P2: begin
                stage_next = 1'b1;
                state_next = dsvf_pkg::ST_G0;
            end
            dsvf_pkg::ST_F2: begin
                // The result waits here until the output register is free.
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = dsvf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dsvf_pkg::step_t'(5'(state_reg + 5'd1));
            end
        endcase
    end

    assign s_ready = (state_reg == dsvf_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: sv/dual_state_variable_filter.sv
// Two chained state-variable filter stages for one audio sample per word.
// Input channel s_*: oscillator samples A and B, a comb sample, resonance,
// per-stage cutoff and FM depth, and the serial/parallel blend gains of stage
// two. Result channel m_*: one saturated Q4.20 sample per input word.
// Both channels use valid/ready; a word moves when both are high.
// Mixing gains, morphs, output gains and the omega limit sit in APB registers
// at byte addresses 0x00 to 0x1C and must be written only while the block is
// idle; the block itself does not enforce this. From acceptance to a valid
// result a word passes through mixing, the first filter stage, the serial and
// parallel blend, the second filter stage and the output sum. One shared
// multiplier serves all products; the damping division of each stage yields
// one quotient bit per cycle. A new word is accepted in the cycle after the
// result is loaded, so words are not overlapped in the filter.
// The result sits in an output register; if the receiver stalls, the next word
// is still accepted and computed and waits only at its final step.
// Reset loads the register defaults and clears all filter state.
module dual_state_variable_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsvf_pkg::AXW-1:0]      paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [23:0]            s_sample_a,
    input  logic signed [23:0]            s_sample_b,
    input  logic signed [23:0]            s_sample_comb,
    input  logic        [20:0]            s_resonance,
    input  logic        [21:0]            s_cut_one,
    input  logic signed [23:0]            s_fm_one,
    input  logic        [21:0]            s_cut_two,
    input  logic signed [23:0]            s_fm_two,
    input  logic signed [21:0]            s_serial_gain,
    input  logic signed [21:0]            s_parallel_gain,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [23:0]            m_out_sample
);

    dsvf_pkg::cfg_t cfg_reg;
    dsvf_pkg::cmd_t cmd;
    logic           div_done;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[dsvf_pkg::AXW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ab_mix          <= 21'd524288;
            cfg_reg.comb_mix        <= 22'sd0;
            cfg_reg.fm_source_mix   <= 21'd524288;
            cfg_reg.morph_stage_one <= 22'sd0;
            cfg_reg.morph_stage_two <= 22'sd0;
            cfg_reg.out_gain_one    <= 22'sd1048576;
            cfg_reg.out_gain_two    <= 22'sd0;
            cfg_reg.omega_limit     <= 22'd1992294;
        end else if (wr_en) begin
            unique case (reg_idx)
                dsvf_pkg::REG_AB_MIX:        cfg_reg.ab_mix          <= pwdata[20:0];
                dsvf_pkg::REG_COMB_MIX:      cfg_reg.comb_mix        <= pwdata[21:0];
                dsvf_pkg::REG_FM_SOURCE_MIX: cfg_reg.fm_source_mix   <= pwdata[20:0];
                dsvf_pkg::REG_MORPH_ONE:     cfg_reg.morph_stage_one <= pwdata[21:0];
                dsvf_pkg::REG_MORPH_TWO:     cfg_reg.morph_stage_two <= pwdata[21:0];
                dsvf_pkg::REG_OUT_GAIN_ONE:  cfg_reg.out_gain_one    <= pwdata[21:0];
                dsvf_pkg::REG_OUT_GAIN_TWO:  cfg_reg.out_gain_two    <= pwdata[21:0];
                dsvf_pkg::REG_OMEGA_LIMIT:   cfg_reg.omega_limit     <= pwdata[21:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dsvf_pkg::REG_AB_MIX:        prdata = 32'(cfg_reg.ab_mix);
            dsvf_pkg::REG_COMB_MIX:      prdata = 32'(cfg_reg.comb_mix);
            dsvf_pkg::REG_FM_SOURCE_MIX: prdata = 32'(cfg_reg.fm_source_mix);
            dsvf_pkg::REG_MORPH_ONE:     prdata = 32'(cfg_reg.morph_stage_one);
            dsvf_pkg::REG_MORPH_TWO:     prdata = 32'(cfg_reg.morph_stage_two);
            dsvf_pkg::REG_OUT_GAIN_ONE:  prdata = 32'(cfg_reg.out_gain_one);
            dsvf_pkg::REG_OUT_GAIN_TWO:  prdata = 32'(cfg_reg.out_gain_two);
            dsvf_pkg::REG_OMEGA_LIMIT:   prdata = 32'(cfg_reg.omega_limit);
            default:                     prdata = '0;
        endcase
    end

    dsvf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .div_done (div_done),
        .cmd      (cmd)
    );

    dsvf_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .sample_a      (s_sample_a),
        .sample_b      (s_sample_b),
        .sample_comb   (s_sample_comb),
        .resonance     (s_resonance),
        .cut_one       (s_cut_one),
        .fm_one        (s_fm_one),
        .cut_two       (s_cut_two),
        .fm_two        (s_fm_two),
        .serial_gain   (s_serial_gain),
        .parallel_gain (s_parallel_gain),
        .div_done      (div_done),
        .out_sample    (m_out_sample)
    );

endmodule
